>>> rtl/iptf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iptf_pkg
// Shared types, sizes and character helpers for the IP address text formatter.
// ----------------------------------------------------------------------------
package iptf_pkg;

	localparam int NUM_GROUPS  = 8;   // IPv6 hex groups
	localparam int NUM_OCTETS  = 4;   // IPv4 octets
	localparam int NUM_SLOTS   = 9;   // one per group plus a trailing colon slot
	localparam int SLOT_CHARS  = 5;   // separator plus up to four digits

	localparam logic [6:0] CH_COLON = 7'h3a;
	localparam logic [6:0] CH_DOT   = 7'h2e;
	localparam logic [6:0] CH_ZERO  = 7'h30;

	typedef struct packed {
		logic [63:0] addr_hi;
		logic [63:0] addr_lo;
		logic        is_v4;
	} in_t;

	typedef struct packed {
		logic [6:0] text_char;
		logic       last_char;
	} out_t;

	// Characters of one formatted address, arranged as fixed slots
	typedef struct packed {
		logic [NUM_SLOTS-1:0][SLOT_CHARS-1:0][6:0] chars;
		logic [NUM_SLOTS-1:0][2:0]                 len;
	} slots_t;

	function automatic logic [6:0] hex_char(input logic [3:0] nib);
		logic [6:0] c;
		if (nib < 4'd10) begin
			c = CH_ZERO + {3'b000, nib};
		end else begin
			c = 7'h57 + {3'b000, nib};
		end
		return c;
	endfunction

	// Split an octet into hundreds, tens and ones by reciprocal multiplication
	function automatic logic [11:0] dec3(input logic [7:0] v);
		logic [14:0] ph;
		logic [1:0]  h;
		logic [7:0]  r8;
		logic [6:0]  r;
		logic [14:0] pt;
		logic [3:0]  t;
		logic [7:0]  o8;
		ph = {7'b0, v} * 15'd41;
		h  = ph[13:12];
		r8 = v - ({6'b0, h} * 8'd100);
		r  = r8[6:0];
		pt = {8'b0, r} * 15'd205;
		t  = pt[14:11];
		o8 = {1'b0, r} - ({4'b0, t} * 8'd10);
		return {2'b00, h, t, o8[3:0]};
	endfunction

endpackage

>>> rtl/iptf_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iptf_serializer
// Walks the character slots of one address and sends one character per
// transaction through a registered output, flagging the final character.
// ----------------------------------------------------------------------------
module iptf_serializer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  iptf_pkg::slots_t in_slots,
	output logic             out_valid,
	input  logic             out_ready,
	output iptf_pkg::out_t   out_data
);

	iptf_pkg::slots_t slots_q;
	logic             busy_q;
	logic [3:0]       cur_q;
	logic [2:0]       pos_q;
	logic             out_valid_q;
	iptf_pkg::out_t   out_q;

	logic       advance;
	logic       slot_end;
	logic       nxt_found;
	logic [3:0] nxt;
	logic       emit_last;
	logic       load;

	always_comb begin
		nxt_found = 1'b0;
		nxt       = cur_q;
		for (int j = iptf_pkg::NUM_SLOTS - 1; j >= 0; j--) begin
			if ((4'(j) > cur_q) && (slots_q.len[j] != 3'd0)) begin
				nxt_found = 1'b1;
				nxt       = 4'(j);
			end
		end
	end

	assign advance   = !out_valid_q || out_ready;
	assign slot_end  = (pos_q + 3'd1) == slots_q.len[cur_q];
	assign emit_last = slot_end && !nxt_found;
	assign in_ready  = !busy_q || (advance && emit_last);
	assign load      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cur_q       <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= busy_q;
			end
			if (load) begin
				busy_q <= 1'b1;
				cur_q  <= '0;
				pos_q  <= '0;
			end else if (advance && busy_q) begin
				if (slot_end) begin
					cur_q <= nxt;
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + 3'd1;
				end
				if (emit_last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slots_q <= in_slots;
		end
		if (advance && busy_q) begin
			out_q.text_char <= slots_q.chars[cur_q][pos_q];
			out_q.last_char <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> rtl/ip_address_text_formatter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_address_text_formatter
// Formats a binary IPv4 or IPv6 address as ASCII text, one character per
// output transaction, with the compressed zero run of IPv6 written as "::".
// ----------------------------------------------------------------------------
// Each address passes three pipeline stages (digit split and zero-group
// detection, longest zero run search, character slot build) and then a
// serializer that sends one character per cycle while out_ready is high;
// an address passes the stage registers and then the serializer's slot and
// output registers. It holds the serializer until its last character (2 to
// 39 for IPv6, 7 to 15 for IPv4) is registered, so that count sets the
// sustained input rate; the next address loads at that same edge, and up
// to three more addresses wait in the pipeline meanwhile.
module ip_address_text_formatter (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  iptf_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output iptf_pkg::out_t out_data
);

	typedef struct packed {
		logic                                                is_v4;
		logic [iptf_pkg::NUM_GROUPS-1:0][15:0]               grp;
		logic [iptf_pkg::NUM_GROUPS-1:0][2:0]                hndig;
		logic [iptf_pkg::NUM_OCTETS-1:0][11:0]               dig;
		logic [iptf_pkg::NUM_OCTETS-1:0][1:0]                ondig;
	} pipe_t;

	logic  en1, en2, en3;
	logic  ser_ready;

	// stage 1
	logic                              valid_s1;
	pipe_t                             data_s1;
	logic [iptf_pkg::NUM_GROUPS-1:0]   zmask_s1;
	pipe_t                             data_c1;
	logic [iptf_pkg::NUM_GROUPS-1:0]   zmask_c1;

	// stage 2
	logic       valid_s2;
	pipe_t      data_s2;
	logic       run_on_s2;
	logic [2:0] run_start_s2;
	logic [3:0] run_end_s2;
	logic       run_on_c2;
	logic [2:0] run_start_c2;
	logic [3:0] run_end_c2;

	// stage 3
	logic             valid_s3;
	iptf_pkg::slots_t slots_s3;
	iptf_pkg::slots_t slots_c3;

	assign en3      = !valid_s3 || ser_ready;
	assign en2      = !valid_s2 || en3;
	assign en1      = !valid_s1 || en2;
	assign in_ready = en1;

	// Split groups and octets, count digits, mark zero groups
	always_comb begin
		data_c1       = '0;
		zmask_c1      = '0;
		data_c1.is_v4 = in_data.is_v4;
		for (int i = 0; i < iptf_pkg::NUM_GROUPS / 2; i++) begin
			data_c1.grp[i]     = in_data.addr_hi[63 - 16 * i -: 16];
			data_c1.grp[i + 4] = in_data.addr_lo[63 - 16 * i -: 16];
		end
		for (int i = 0; i < iptf_pkg::NUM_GROUPS; i++) begin
			zmask_c1[i] = (data_c1.grp[i] == 16'd0);
			if (data_c1.grp[i][15:12] != 4'd0) begin
				data_c1.hndig[i] = 3'd4;
			end else if (data_c1.grp[i][11:8] != 4'd0) begin
				data_c1.hndig[i] = 3'd3;
			end else if (data_c1.grp[i][7:4] != 4'd0) begin
				data_c1.hndig[i] = 3'd2;
			end else begin
				data_c1.hndig[i] = 3'd1;
			end
		end
		for (int i = 0; i < iptf_pkg::NUM_OCTETS; i++) begin
			data_c1.dig[i] = iptf_pkg::dec3(in_data.addr_hi[63 - 8 * i -: 8]);
			if (in_data.addr_hi[63 - 8 * i -: 8] >= 8'd100) begin
				data_c1.ondig[i] = 2'd3;
			end else if (in_data.addr_hi[63 - 8 * i -: 8] >= 8'd10) begin
				data_c1.ondig[i] = 2'd2;
			end else begin
				data_c1.ondig[i] = 2'd1;
			end
		end
	end

	// Longest run of zero groups, first one wins on a tie
	always_comb begin
		logic [3:0] cur_len;
		logic [2:0] cur_start;
		logic [3:0] best_len;
		logic [2:0] best_start;
		cur_len    = '0;
		cur_start  = '0;
		best_len   = '0;
		best_start = '0;
		for (int i = 0; i < iptf_pkg::NUM_GROUPS; i++) begin
			if (zmask_s1[i]) begin
				if (cur_len == 4'd0) begin
					cur_start = 3'(i);
				end
				cur_len = cur_len + 4'd1;
				if (cur_len > best_len) begin
					best_len   = cur_len;
					best_start = cur_start;
				end
			end else begin
				cur_len = '0;
			end
		end
		run_on_c2    = (best_len >= 4'd2);
		run_start_c2 = best_start;
		run_end_c2   = {1'b0, best_start} + best_len;
	end

	// Lay out separators and digits into per-group slots
	always_comb begin
		logic [2:0] k;
		logic       in_run;
		slots_c3 = '0;
		k        = '0;
		in_run   = 1'b0;
		for (int i = 0; i < iptf_pkg::NUM_GROUPS; i++) begin
			for (int c = 0; c < iptf_pkg::SLOT_CHARS; c++) begin
				slots_c3.chars[i][c] = iptf_pkg::CH_ZERO;
			end
			k = '0;
			if (data_s2.is_v4) begin
				if (i < iptf_pkg::NUM_OCTETS) begin
					if (i != 0) begin
						slots_c3.chars[i][k] = iptf_pkg::CH_DOT;
						k = k + 3'd1;
					end
					if (data_s2.ondig[i] == 2'd3) begin
						slots_c3.chars[i][k] = iptf_pkg::hex_char(data_s2.dig[i][11:8]);
						k = k + 3'd1;
					end
					if (data_s2.ondig[i] >= 2'd2) begin
						slots_c3.chars[i][k] = iptf_pkg::hex_char(data_s2.dig[i][7:4]);
						k = k + 3'd1;
					end
					slots_c3.chars[i][k] = iptf_pkg::hex_char(data_s2.dig[i][3:0]);
					k = k + 3'd1;
				end
				slots_c3.len[i] = k;
			end else begin
				in_run = run_on_s2 && (3'(i) >= run_start_s2) && (4'(i) < run_end_s2);
				if (in_run) begin
					if (3'(i) == run_start_s2) begin
						slots_c3.chars[i][0] = iptf_pkg::CH_COLON;
						k = 3'd1;
					end
				end else begin
					if (i != 0) begin
						slots_c3.chars[i][k] = iptf_pkg::CH_COLON;
						k = k + 3'd1;
					end
					for (int j = 3; j >= 0; j--) begin
						if (3'(j) < data_s2.hndig[i]) begin
							slots_c3.chars[i][k] = iptf_pkg::hex_char(data_s2.grp[i][4 * j +: 4]);
							k = k + 3'd1;
						end
					end
				end
				slots_c3.len[i] = k;
			end
		end
		// trailing colon when the zero run reaches the end
		for (int c = 0; c < iptf_pkg::SLOT_CHARS; c++) begin
			slots_c3.chars[iptf_pkg::NUM_SLOTS-1][c] = iptf_pkg::CH_COLON;
		end
		if (!data_s2.is_v4 && run_on_s2 && (run_end_s2 == 4'(iptf_pkg::NUM_GROUPS))) begin
			slots_c3.len[iptf_pkg::NUM_SLOTS-1] = 3'd1;
		end else begin
			slots_c3.len[iptf_pkg::NUM_SLOTS-1] = 3'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en1) begin
				valid_s1 <= in_valid;
			end
			if (en2) begin
				valid_s2 <= valid_s1;
			end
			if (en3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			data_s1  <= data_c1;
			zmask_s1 <= zmask_c1;
		end
		if (en2) begin
			data_s2      <= data_s1;
			run_on_s2    <= run_on_c2;
			run_start_s2 <= run_start_c2;
			run_end_s2   <= run_end_c2;
		end
		if (en3) begin
			slots_s3 <= slots_c3;
		end
	end

	iptf_serializer u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s3),
		.in_ready  (ser_ready),
		.in_slots  (slots_s3),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
